@@ src/threshold_morphology_3x3_macros.svh @@
// Assertion macros for the threshold morphology block.
// Included by the top level; no other dependencies.
`ifndef THRESHOLD_MORPHOLOGY_3X3_MACROS_SVH
`define THRESHOLD_MORPHOLOGY_3X3_MACROS_SVH

`ifndef SYNTHESIS

// a implies b in the same cycle
`define TM3_ASSERT_IMP(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
    else $error("tm3 assertion failed");

// a implies b in the next cycle
`define TM3_ASSERT_NXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
    else $error("tm3 assertion failed");

`else

`define TM3_ASSERT_IMP(lbl, ck, rn, a, b)
`define TM3_ASSERT_NXT(lbl, ck, rn, a, b)

`endif

`endif

@@ src/tm3_pkg.sv @@
// Shared types, constants and the window test for threshold_morphology_3x3.
// No dependencies.
package tm3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 12;
  localparam int FH_W      = 16;
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W     = ((W_W > FW_W) ? W_W : FW_W) + 1;
  localparam int NUM_CELLS = 2;
  localparam int ADDR_W    = 5;

  localparam logic [7:0] THRESH_RST = 8'd200;
  localparam logic [7:0] PIX_SET    = 8'd255;
  localparam logic [7:0] PIX_CLR    = 8'd0;
  localparam logic [8:0] MASK_CROSS = 9'h0BA;
  localparam logic [8:0] MASK_RECT  = 9'h1FF;
  localparam logic [FW_W-1:0] WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RST = FH_W'(480);
  localparam int MIN_DIM = 3;
  localparam int MARGIN  = 2;

  typedef enum logic [2:0] {
    REG_OPERATION    = 3'd0,
    REG_SHAPE        = 3'd1,
    REG_THRESHOLD    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  localparam logic OP_EROSION  = 1'b0;
  localparam logic SHAPE_CROSS = 1'b0;

  // one window column, top row in bit 2
  typedef logic [2:0] col_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;   // bit 1: row r-2, bit 0: row r-1
  } ls_wr_t;

  function automatic logic morph_hit(input logic [8:0] win, input logic op,
                                     input logic shape);
    logic [8:0] mask;
    logic [8:0] sel;
    mask = (shape == SHAPE_CROSS) ? MASK_CROSS : MASK_RECT;
    sel  = win & mask;
    return (op == OP_EROSION) ? (sel == mask) : (sel != 9'd0);
  endfunction

endpackage

@@ src/tm3_col_cell.sv @@
// One column cell of the 3x3 window: holds three bits, passes them on.
// Depends on tm3_pkg.
module tm3_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  tm3_pkg::col_t col_in,
  output tm3_pkg::col_t col_q
);
  import tm3_pkg::*;

  col_t col_r;
  col_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_q = col_r;

endmodule

@@ src/tm3_line_store.sv @@
// Two line stores of binarized pixels, packed as one 2-bit-wide memory.
// Registered read port, one write port. Depends on tm3_pkg.
module tm3_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tm3_pkg::COL_W-1:0] rd_addr,
  input  tm3_pkg::ls_wr_t           wr,
  output logic [1:0]                rd_data
);
  import tm3_pkg::*;

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/threshold_morphology_3x3.sv @@
// Streaming 3x3 binary erosion/dilation on thresholded grey pixels. The block
// accepts one pixel per clock in raster order when not stalled and delivers
// one result per clock for interior positions; border positions produce no
// transfer. A result leaves after the pixel at (r+1,c+1) is accepted, by way
// of the registered line-store read and then the window update into the output
// register. Output backpressure stalls the whole two-stage pipe. The line
// stores are not cleared after reset; the first two rows of the first frame
// only fill them, so no result depends on unwritten entries.
`include "threshold_morphology_3x3_macros.svh"

module threshold_morphology_3x3 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_pixel_out,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tm3_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tm3_pkg::*;

  // configuration
  logic            op_r;
  logic            shape_r;
  logic [7:0]      thr_r;
  logic [FW_W-1:0] fwidth_r;
  logic [FH_W-1:0] fheight_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= OP_EROSION;
      shape_r   <= ~SHAPE_CROSS;
      thr_r     <= THRESH_RST;
      fwidth_r  <= WIDTH_RST;
      fheight_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OPERATION:    op_r      <= pwdata[0];
        REG_SHAPE:        shape_r   <= pwdata[0];
        REG_THRESHOLD:    thr_r     <= pwdata[7:0];
        REG_FRAME_WIDTH:  fwidth_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fheight_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OPERATION:    prdata = {31'd0, op_r};
      REG_SHAPE:        prdata = {31'd0, shape_r};
      REG_THRESHOLD:    prdata = {24'd0, thr_r};
      REG_FRAME_WIDTH:  prdata = {{(32-FW_W){1'b0}}, fwidth_r};
      REG_FRAME_HEIGHT: prdata = {{(32-FH_W){1'b0}}, fheight_r};
      default:          prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic stall;
  logic accept;
  logic out_valid_r;

  assign stall    = out_valid_r && !out_ready;
  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;

  // position counters and stage-0 decode
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [FH_W-1:0]  row_r;
  logic [FH_W-1:0]  row_nxt;
  logic [CNT_W-1:0] eff_w;
  logic [CNT_W-1:0] fw_ext;
  logic [CNT_W-1:0] col_plus;
  logic [FH_W:0]    eff_h;
  logic [FH_W:0]    row_plus;
  logic             row_end;
  logic             frame_end;
  logic             emit0;
  logic             cur0;

  always_comb begin
    fw_ext = CNT_W'(fwidth_r);
    if (fw_ext < CNT_W'(MIN_DIM)) begin
      eff_w = CNT_W'(MIN_DIM);
    end else if (fw_ext > CNT_W'(MAX_WIDTH)) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (fheight_r < FH_W'(MIN_DIM)) ? (FH_W + 1)'(MIN_DIM) : {1'b0, fheight_r};
    col_plus  = CNT_W'(col_r) + CNT_W'(1);
    row_plus  = {1'b0, row_r} + (FH_W + 1)'(1);
    row_end   = col_plus >= eff_w;
    frame_end = row_end && (row_plus >= eff_h);
    emit0     = (row_r >= FH_W'(MARGIN)) && (col_r >= COL_W'(MARGIN));
    cur0      = in_pixel_in > thr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_plus[FH_W-1:0];
      end else begin
        col_nxt = col_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line-store data arrives, window shifts
  logic             s1_valid_r;
  logic             s1_cur_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= cur0;
      s1_emit_r <= emit0;
      s1_last_r <= frame_end;
      s1_col_r  <= col_r;
    end
  end

  logic       adv1;
  logic [1:0] ls_rd;
  ls_wr_t     ls_wr;
  col_t       new_col;

  assign adv1    = s1_valid_r && !stall;
  assign new_col = {ls_rd[1], ls_rd[0], s1_cur_r};

  always_comb begin
    ls_wr.en   = adv1;
    ls_wr.addr = s1_col_r;
    ls_wr.data = {ls_rd[0], s1_cur_r};
  end

  tm3_line_store u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .wr      (ls_wr),
    .rd_data (ls_rd)
  );

  // cell chain: cell 0 holds column c-1, cell 1 holds column c-2
  col_t cell_in [NUM_CELLS];
  col_t cell_q  [NUM_CELLS];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign cell_in[gi] = new_col;
      end else begin : g_link
        assign cell_in[gi] = cell_q[gi-1];
      end
      tm3_col_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv1),
        .col_in   (cell_in[gi]),
        .col_q    (cell_q[gi])
      );
    end
  endgenerate

  logic [8:0] win;
  logic       hit;

  assign win = {cell_q[1], cell_q[0], new_col};
  assign hit = morph_hit(win, op_r, shape_r);

  // output register
  logic [7:0] pix_out_r;
  logic       last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= adv1 && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      pix_out_r  <= hit ? PIX_SET : PIX_CLR;
      last_out_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = pix_out_r;
  assign out_frame_last = last_out_r;

  // checks
  `TM3_ASSERT_IMP(a_pix_code, clk, rst_n, out_valid_r,
                  (pix_out_r == PIX_SET) || (pix_out_r == PIX_CLR))
  `TM3_ASSERT_IMP(a_last_wraps, clk, rst_n, s1_valid_r && s1_last_r,
                  (col_r == '0) && (row_r == '0))
  `TM3_ASSERT_IMP(a_ls_no_collide, clk, rst_n, ls_wr.en && accept,
                  ls_wr.addr != col_r)

endmodule
